// ===== src/gpa_pkg.sv =====
`default_nettype none

package gpa_pkg;

  // bin grid
  localparam int unsigned NATIONS = 25;
  localparam int unsigned YEARS   = 7;
  localparam int unsigned BINS    = NATIONS * YEARS;
  localparam int unsigned BIN_W   = (BINS > 1) ? $clog2(BINS) : 1;

  // field widths
  localparam int unsigned YEAR_W     = 23;
  localparam int unsigned YEAR_LSB   = 9;
  localparam int unsigned YOFF_W     = 3;
  localparam int unsigned NAT_W      = 8;
  localparam int unsigned RNAT_W     = 5;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned GAIN_W     = 41;
  localparam int unsigned CQ_W       = 48;
  localparam int unsigned IDX_CALC_W = YOFF_W + NAT_W;

  // constants
  localparam logic [YEAR_W-1:0] BASE_YEAR_RESET = YEAR_W'(1992);
  localparam logic [7:0]        HUNDRED         = 8'd100;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_BAD_READ = 2'd2
  } gpa_status_e;

  // write request into the bin store
  typedef struct packed {
    logic             en;
    logic [BIN_W-1:0] idx;
    logic [SUM_W-1:0] data;
  } gpa_wr_t;

endpackage

`default_nettype wire

// ===== src/gpa_in_if.sv =====
`default_nettype none

interface gpa_in_if;
  import gpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [31:0]       order_date;
  logic [NAT_W-1:0]  nation;
  logic [31:0]       extended_price;
  logic [6:0]        discount;
  logic [31:0]       supply_cost;
  logic [15:0]       quantity;
  logic [YOFF_W-1:0] read_year_offset;
  logic [RNAT_W-1:0] read_nation;

  modport source (
    output valid, mode, order_date, nation, extended_price, discount,
           supply_cost, quantity, read_year_offset, read_nation,
    input  ready
  );

  modport sink (
    input  valid, mode, order_date, nation, extended_price, discount,
           supply_cost, quantity, read_year_offset, read_nation,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/gpa_out_if.sv =====
`default_nettype none

interface gpa_out_if;
  import gpa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] bin_sum;
  logic [1:0]              status;

  modport source (
    output valid, bin_sum, status,
    input  ready
  );

  modport sink (
    input  valid, bin_sum, status,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/grouped_profit_accumulator_core.sv =====
// channel   dir   handshake      payload
// rows_i    in    valid/ready    mode, order_date, nation, extended_price, discount,
//                                supply_cost, quantity, read_year_offset, read_nation
// sums_o    out   valid/ready    bin_sum, status
// cfg       in    cfg_we_i       cfg_wdata_i (base_year)
//
// one beat per cycle in and out while the result register is not blocked
// the loop that sets this is the bin memory read (stage 1) and add/write-back
// (stage 2), with a one-deep bypass for hits on the same bin in adjacent beats
// reset clears the per-bin written flags at once, so no clearing pass is needed
// when the result register is full and not taken, the whole pipe holds

`default_nettype none

module grouped_profit_accumulator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gpa_pkg::YEAR_W-1:0] cfg_wdata_i,
  gpa_in_if.sink                     rows_i,
  gpa_out_if.source                  sums_o
);
  import gpa_pkg::*;

  logic [YEAR_W-1:0]     base_year_q;
  logic                  adv;

  // stage 0 signals
  logic [YEAR_W-1:0]     year;
  logic [YEAR_W:0]       ydiff;
  logic                  yr_ok;
  logic                  nat_ok;
  logic                  rd_ok;
  logic [YOFF_W-1:0]     yoff_sel;
  logic [NAT_W-1:0]      nat_sel;
  logic [IDX_CALC_W-1:0] idx_calc;
  gpa_status_e           status_d;
  logic [7:0]            factor;
  logic signed [GAIN_W-1:0] gain_d;
  logic [CQ_W-1:0]       cq_d;

  // stage 1 registers
  logic                  s1_valid_q;
  logic                  s1_mode_q;
  gpa_status_e           s1_status_q;
  logic [BIN_W-1:0]      s1_idx_q;
  logic signed [GAIN_W-1:0] s1_gain_q;
  logic [CQ_W-1:0]       s1_cq_q;

  // stage 2 registers
  logic                  s2_valid_q;
  logic                  s2_mode_q;
  gpa_status_e           s2_status_q;
  logic [BIN_W-1:0]      s2_idx_q;
  logic [SUM_W-1:0]      s2_profit_q;
  logic [SUM_W-1:0]      profit_d;

  // result register
  logic                  out_valid_q;
  logic [SUM_W-1:0]      out_sum_q;
  gpa_status_e           out_status_q;

  gpa_wr_t               wr;
  logic [SUM_W-1:0]      bin_old;
  logic [SUM_W-1:0]      bin_new;

  // base year register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q <= BASE_YEAR_RESET;
    end else if (cfg_we_i) begin
      base_year_q <= cfg_wdata_i;
    end
  end

  // pipe moves whenever the result register is free
  assign adv          = !out_valid_q || sums_o.ready;
  assign rows_i.ready = adv;

  // range checks and bin index
  always_comb begin
    year     = rows_i.order_date[31:YEAR_LSB];
    ydiff    = {1'b0, year} - {1'b0, base_year_q};
    yr_ok    = !ydiff[YEAR_W] && (ydiff[YEAR_W-1:0] < YEAR_W'(YEARS));
    nat_ok   = rows_i.nation < NAT_W'(NATIONS);
    rd_ok    = ({1'b0, rows_i.read_year_offset} < (YOFF_W + 1)'(YEARS)) &&
               (NAT_W'(rows_i.read_nation) < NAT_W'(NATIONS));
    yoff_sel = rows_i.mode ? rows_i.read_year_offset : ydiff[YOFF_W-1:0];
    nat_sel  = rows_i.mode ? NAT_W'(rows_i.read_nation) : rows_i.nation;
    idx_calc = IDX_CALC_W'(yoff_sel) * IDX_CALC_W'(NATIONS) + IDX_CALC_W'(nat_sel);
    if (rows_i.mode) begin
      status_d = rd_ok ? ST_OK : ST_BAD_READ;
    end else begin
      status_d = (yr_ok && nat_ok) ? ST_OK : ST_DROPPED;
    end
  end

  // gain and cost products; factor goes negative above one hundred
  assign factor = HUNDRED - {1'b0, rows_i.discount};
  assign gain_d = GAIN_W'($signed({1'b0, rows_i.extended_price})) *
                  GAIN_W'($signed(factor));
  assign cq_d   = CQ_W'(rows_i.supply_cost) * CQ_W'(rows_i.quantity);

  // stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= rows_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mode_q   <= rows_i.mode;
      s1_status_q <= status_d;
      s1_idx_q    <= idx_calc[BIN_W-1:0];
      s1_gain_q   <= gain_d;
      s1_cq_q     <= cq_d;
    end
  end

  // profit = gain - cost*qty*100, times 100 as 64 + 32 + 4
  always_comb begin
    profit_d = {{(SUM_W - GAIN_W){s1_gain_q[GAIN_W-1]}}, s1_gain_q}
             - (SUM_W'(s1_cq_q) << 6)
             - (SUM_W'(s1_cq_q) << 5)
             - (SUM_W'(s1_cq_q) << 2);
  end

  // stage 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_mode_q   <= s1_mode_q;
      s2_status_q <= s1_status_q;
      s2_idx_q    <= s1_idx_q;
      s2_profit_q <= profit_d;
    end
  end

  // read-modify-write of the bin
  assign bin_new = bin_old + s2_profit_q;

  always_comb begin
    wr.en   = adv && s2_valid_q && !s2_mode_q && (s2_status_q == ST_OK);
    wr.idx  = s2_idx_q;
    wr.data = bin_new;
  end

  gpa_bin_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (adv),
    .rd_idx_i  (s1_idx_q),
    .wr_i      (wr),
    .rd_data_o (bin_old)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_sum_q    <= (s2_mode_q && (s2_status_q == ST_OK)) ? bin_old : '0;
      out_status_q <= s2_status_q;
    end
  end

  assign sums_o.valid   = out_valid_q;
  assign sums_o.bin_sum = $signed(out_sum_q);
  assign sums_o.status  = out_status_q;

endmodule

`default_nettype wire

// ===== src/gpa_bin_store.sv =====
`default_nettype none

module gpa_bin_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [gpa_pkg::BIN_W-1:0]     rd_idx_i,
  input  gpa_pkg::gpa_wr_t              wr_i,
  output logic [gpa_pkg::SUM_W-1:0]     rd_data_o
);
  import gpa_pkg::*;

  logic [SUM_W-1:0] mem [BINS];
  logic [BINS-1:0]  vld_q;
  logic [SUM_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic             fwd_q;
  logic [SUM_W-1:0] fwd_data_q;

  // sum memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  // written flags, an unwritten bin reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
        fwd_q    <= wr_i.en && (wr_i.idx == rd_idx_i);
      end
    end
  end

  // write landing in the same cycle as the read is bypassed
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_i.data;
    end
  end

  always_comb begin
    if (fwd_q) begin
      rd_data_o = fwd_data_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_data_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/gpa_checker.sv =====
`default_nettype none

module gpa_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [gpa_pkg::SUM_W-1:0] out_sum_i,
  input logic [1:0]               out_status_i
);
  import gpa_pkg::*;

  // a result beat stays up until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sum_i) &&
    $stable(out_status_i))
    else $error("result beat dropped or changed while stalled");

  // a blocked result stalls the input side
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while result is blocked");

  // only known status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i == ST_OK) || (out_status_i == ST_DROPPED) ||
    (out_status_i == ST_BAD_READ))
    else $error("unknown status code");

  // dropped rows and bad reads carry a zero sum
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> out_sum_i == '0)
    else $error("nonzero sum on an error beat");

endmodule

bind grouped_profit_accumulator_core gpa_checker u_gpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (rows_i.ready),
  .out_valid_i  (sums_o.valid),
  .out_ready_i  (sums_o.ready),
  .out_sum_i    (sums_o.bin_sum),
  .out_status_i (sums_o.status)
);

`default_nettype wire
